### rtl/rct_pkg.sv
// Shared types, constants and the arctangent table of the raised-cosine generator.
`default_nettype none
package rct_pkg;

  localparam int PHASE_BITS_DEF = 16;
  localparam int CORDIC_STEPS   = 30;
  localparam int VEC_W          = 33;   // Q2.30 vector plus headroom
  localparam int ANG_W          = 32;   // turn angle residue

  localparam logic [1:0] REG_AMPLITUDE = 2'd0;
  localparam logic [1:0] REG_FREQUENCY = 2'd1;
  localparam logic [1:0] REG_AXIS_EN   = 2'd2;

  localparam logic signed [VEC_W-1:0] CORDIC_K = 33'sh026DD3B6A;
  localparam logic [31:0]             PI_Q30   = 32'd3373259426;

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  typedef struct packed {
    logic                     vld;
    logic signed [VEC_W-1:0]  x;
    logic signed [VEC_W-1:0]  y;
    logic signed [ANG_W-1:0]  z;
  } rct_vec_t;

endpackage
`default_nettype wire

### rtl/rct_cordic_cell.sv
// One CORDIC rotation cell; cells are chained, each with a fixed shift.
`default_nettype none
module rct_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rct_pkg::rct_vec_t din,
  output rct_pkg::rct_vec_t      dout
);

  logic signed [rct_pkg::VEC_W-1:0] dx;
  logic signed [rct_pkg::VEC_W-1:0] dy;
  logic signed [rct_pkg::ANG_W-1:0] da;

  assign dx = din.y >>> STEP;
  assign dy = din.x >>> STEP;
  assign da = $signed(rct_pkg::ATAN_TURNS[STEP]);

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    // floor shifts; rotate toward zero residue
    if (din.z >= 0) begin
      dout.x <= din.x - dx;
      dout.y <= din.y + dy;
      dout.z <= din.z - da;
    end else begin
      dout.x <= din.x + dx;
      dout.y <= din.y - dy;
      dout.z <= din.z + da;
    end
  end

endmodule
`default_nettype wire

### rtl/raised_cosine_trajectory_generator_unit.sv
// Top level: three-axis raised-cosine set-point generator.
// Path from input request to result valid: 1 phase multiply, 1 launch, 30 CORDIC
//   cells, 1 quadrant fold, 5 shared-multiplier steps, 1 output.
// Requests: the CORDIC cell chain and the single 33x33 multiplier serve one request
//   at a time, so a new request is taken only in the idle state. A new request is
//   taken while the previous result still waits in the output register.
// Reset: synchronous, active high; clears config, state, sticky finished flag, valids.
`default_nettype none
module raised_cosine_trajectory_generator_unit #(
  parameter int PHASE_BITS = rct_pkg::PHASE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write port
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [23:0]        cfg_data,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [31:0]        time_now,
  // output channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [23:0]      pos_x,
  output logic signed [23:0]      pos_y,
  output logic signed [23:0]      pos_z,
  output logic signed [39:0]      vel_x,
  output logic signed [39:0]      vel_y,
  output logic signed [39:0]      vel_z,
  output logic                    finished
);

  localparam int VW = rct_pkg::VEC_W;
  localparam int NS = rct_pkg::CORDIC_STEPS;

  typedef enum logic [3:0] {
    S_IDLE, S_PHASE, S_START, S_WAIT, S_MPOS, S_MSPI,
    S_MAF, S_MVLO, S_MVHI, S_VSUM
  } state_t;

  state_t state;

  // configuration registers
  logic signed [23:0] amplitude;
  logic [23:0]        frequency;
  logic [2:0]         axis_enable;
  logic               done_q;

  logic [31:0]        t_reg;
  logic [1:0]         quad;
  logic signed [VW-1:0] c_reg;
  logic signed [VW-1:0] s_reg;

  // shared multiplier
  logic [32:0]        mul_a;
  logic [32:0]        mul_b;
  logic [65:0]        prod;
  logic               mul_go;

  logic [24:0]        pos_mag;
  logic               pos_neg;
  logic [32:0]        spi_mag;
  logic               spi_neg;
  logic [22:0]        af_hi;
  logic [56:0]        acc;

  // CORDIC cell chain
  rct_pkg::rct_vec_t  launch;
  rct_pkg::rct_vec_t  chain [NS+1];

  logic [23:0]        amp_mag;
  logic signed [33:0] d_val;
  logic [32:0]        d_mag;
  logic [32:0]        s_mag;
  logic [55:0]        p_val;
  logic [31:0]        angle;
  logic [55:0]        psum;
  logic [63:0]        ssum;
  logic [80:0]        vsum;
  logic [34:0]        vel_mag;
  logic signed [25:0] pos_s;
  logic signed [23:0] pos_sat;
  logic signed [39:0] vel_s;
  logic               res_ready;

  assign in_stall  = (state != S_IDLE);
  assign amp_mag   = amplitude[23] ? 24'(-amplitude) : amplitude;
  assign d_val     = 34'sh040000000 - 34'(c_reg);
  assign d_mag     = d_val[33] ? 33'(-d_val) : d_val[32:0];
  assign s_mag     = s_reg[VW-1] ? 33'(-s_reg) : s_reg;
  assign p_val     = prod[55:0];
  // fractional turn truncated to PHASE_BITS
  assign angle     = {p_val[31 -: PHASE_BITS], {(32-PHASE_BITS){1'b0}}};
  assign psum      = 56'(prod[54:0]) + (56'd1 << 30);
  assign ssum      = prod[63:0] + (64'd1 << 29);
  assign vsum      = (81'(prod[55:0]) << 24) + 81'(acc) + (81'd1 << 45);
  assign vel_mag   = vsum[80:46];
  assign res_ready = !out_valid || !out_stall;

  always_comb begin
    pos_s = pos_neg ? -26'(pos_mag) : 26'(pos_mag);
    if (pos_s > 26'sd8388607) begin
      pos_sat = 24'sh7FFFFF;
    end else if (pos_s < -26'sd8388608) begin
      pos_sat = 24'sh800000;
    end else begin
      pos_sat = pos_s[23:0];
    end
    // |velocity| stays below 2^34, so the 40-bit range always holds it
    vel_s = (amplitude[23] ^ spi_neg) ? -40'(vel_mag) : 40'(vel_mag);
  end

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_go = 1'b1;
    case (state)
      S_PHASE: begin
        mul_a = 33'(frequency);
        mul_b = 33'(t_reg);
      end
      S_MPOS: begin
        mul_a = 33'(amp_mag);
        mul_b = d_mag;
      end
      S_MSPI: begin
        mul_a = s_mag;
        mul_b = 33'(rct_pkg::PI_Q30);
      end
      S_MAF: begin
        mul_a = 33'(amp_mag);
        mul_b = 33'(frequency);
      end
      S_MVLO: begin
        mul_a = 33'(prod[23:0]);
        mul_b = spi_mag;
      end
      S_MVHI: begin
        mul_a = 33'(af_hi);
        mul_b = spi_mag;
      end
      default: begin
        mul_go = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_go) begin
      prod <= mul_a * mul_b;
    end
  end

  assign chain[0] = launch;

  for (genvar i = 0; i < NS; i++) begin : g_cell
    rct_cordic_cell #(.STEP(i)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      amplitude   <= '0;
      frequency   <= '0;
      axis_enable <= '0;
      done_q      <= 1'b0;
      launch.vld  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          rct_pkg::REG_AMPLITUDE: amplitude   <= cfg_data;
          rct_pkg::REG_FREQUENCY: frequency   <= cfg_data;
          rct_pkg::REG_AXIS_EN:   axis_enable <= cfg_data[2:0];
          default: ;
        endcase
      end
      // a result leaving while the next one is written keeps valid high
      if (out_valid && !out_stall && state != S_VSUM) begin
        out_valid <= 1'b0;
      end
      launch.vld <= (state == S_START);
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            t_reg <= time_now;
            state <= S_PHASE;
          end
        end
        S_PHASE: begin
          state <= S_START;
        end
        S_START: begin
          // f*t beyond one full period
          if (p_val > 56'h100000000) begin
            done_q <= 1'b1;
          end
          quad       <= angle[31:30];
          launch.x   <= rct_pkg::CORDIC_K;
          launch.y   <= '0;
          launch.z   <= $signed({2'b00, angle[29:0]});
          state      <= S_WAIT;
        end
        S_WAIT: begin
          if (chain[NS].vld) begin
            case (quad)
              2'd0: begin
                c_reg <= chain[NS].x;
                s_reg <= chain[NS].y;
              end
              2'd1: begin
                c_reg <= -chain[NS].y;
                s_reg <= chain[NS].x;
              end
              2'd2: begin
                c_reg <= -chain[NS].x;
                s_reg <= -chain[NS].y;
              end
              default: begin
                c_reg <= chain[NS].y;
                s_reg <= -chain[NS].x;
              end
            endcase
            state <= S_MPOS;
          end
        end
        S_MPOS: begin
          pos_neg <= amplitude[23] ^ d_val[33];
          state   <= S_MSPI;
        end
        S_MSPI: begin
          pos_mag <= psum[55:31];
          spi_neg <= s_reg[VW-1];
          state   <= S_MAF;
        end
        S_MAF: begin
          spi_mag <= ssum[62:30];
          state   <= S_MVLO;
        end
        S_MVLO: begin
          af_hi <= prod[46:24];
          state <= S_MVHI;
        end
        S_MVHI: begin
          acc   <= prod[56:0];
          state <= S_VSUM;
        end
        S_VSUM: begin
          if (res_ready) begin
            out_valid <= 1'b1;
            pos_x     <= axis_enable[0] ? pos_sat : '0;
            pos_y     <= axis_enable[1] ? pos_sat : '0;
            pos_z     <= axis_enable[2] ? pos_sat : '0;
            vel_x     <= axis_enable[0] ? vel_s : '0;
            vel_y     <= axis_enable[1] ? vel_s : '0;
            vel_z     <= axis_enable[2] ? vel_s : '0;
            finished  <= done_q;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_chain_wait: assert property (@(posedge clk) disable iff (rst)
    chain[NS].vld |-> state == S_WAIT)
    else $error("CORDIC result arrived outside wait state");
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    done_q |=> done_q)
    else $error("finished flag cleared without reset");
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == S_PHASE)
    else $error("accepted request did not start phase multiply");
`endif

endmodule
`default_nettype wire

### tb/sv/tb.sv
// Testbench for the raised-cosine set-point generator: scoreboard class and driver tasks.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One expected set-point, all seven fields.
  typedef struct {
    logic signed [23:0] px, py, pz;
    logic signed [39:0] vx, vy, vz;
    logic               fin;
  } setpoint_t;

  // Scoreboard: holds its own copy of the registers and the sticky flag.
  class setpoint_board;
    longint    amp;
    longint    freq;
    bit [2:0]  axes;
    bit        done;
    setpoint_t owed[$];
    int        fails;
    int        seen;

    function new();
      amp = 0; freq = 0; axes = 0; done = 0; fails = 0; seen = 0;
    endfunction

    // round(a*b / 2^sh), halves away from zero
    function longint round_mul(longint a, longint b, int sh);
      bit neg;
      logic [127:0] ma, mb, m;
      neg = (a < 0) != (b < 0);
      ma = 128'(a < 0 ? -a : a);
      mb = 128'(b < 0 ? -b : b);
      m = (ma * mb + (128'd1 << (sh - 1))) >> sh;
      return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function void note_request(bit [31:0] t);
      logic [63:0] p;
      bit [31:0] ang;
      longint x, y, z, dx, dy, c, s, pos, vel, spi;
      setpoint_t e;
      p = 64'(freq) * 64'(t);
      ang = {p[31:16], 16'h0};
      if (p > 64'h1_0000_0000) done = 1;
      x = longint'(rct_pkg::CORDIC_K); y = 0; z = longint'(ang & 32'h3FFF_FFFF);
      for (int i = 0; i < rct_pkg::CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(rct_pkg::ATAN_TURNS[i]);
        end else begin
          x += dx; y -= dy; z += longint'(rct_pkg::ATAN_TURNS[i]);
        end
      end
      case (ang[31:30])
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
      pos = round_mul(amp, (longint'(1) << 30) - c, 31);
      if (pos > 8388607) pos = 8388607;
      if (pos < -8388608) pos = -8388608;
      spi = round_mul(s, longint'(rct_pkg::PI_Q30), 30);
      vel = round_mul(amp * freq, spi, 46);
      if (vel > 64'sd549755813887) vel = 64'sd549755813887;
      if (vel < -64'sd549755813888) vel = -64'sd549755813888;
      e.px = axes[0] ? pos[23:0] : '0;
      e.py = axes[1] ? pos[23:0] : '0;
      e.pz = axes[2] ? pos[23:0] : '0;
      e.vx = axes[0] ? vel[39:0] : '0;
      e.vy = axes[1] ? vel[39:0] : '0;
      e.vz = axes[2] ? vel[39:0] : '0;
      e.fin = done;
      owed.push_back(e);
    endfunction

    function void check_result(setpoint_t a);
      setpoint_t e;
      seen++;
      if (owed.size() == 0) begin
        $error("set-point with no request outstanding");
        fails++;
        return;
      end
      e = owed.pop_front();
      if (a.px !== e.px) begin $error("pos_x exp %0d got %0d", e.px, a.px); fails++; end
      if (a.py !== e.py) begin $error("pos_y exp %0d got %0d", e.py, a.py); fails++; end
      if (a.pz !== e.pz) begin $error("pos_z exp %0d got %0d", e.pz, a.pz); fails++; end
      if (a.vx !== e.vx) begin $error("vel_x exp %0d got %0d", e.vx, a.vx); fails++; end
      if (a.vy !== e.vy) begin $error("vel_y exp %0d got %0d", e.vy, a.vy); fails++; end
      if (a.vz !== e.vz) begin $error("vel_z exp %0d got %0d", e.vz, a.vz); fails++; end
      if (a.fin !== e.fin) begin $error("finished exp %0d got %0d", e.fin, a.fin); fails++; end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_write = 0;
  logic [1:0]         cfg_index = rct_pkg::REG_AMPLITUDE;
  logic [23:0]        cfg_data = '0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [31:0]        time_now = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [23:0] pos_x, pos_y, pos_z;
  logic signed [39:0] vel_x, vel_y, vel_z;
  logic               finished;

  setpoint_board board = new();
  bit quiet = 0;     // when set, neither side idles
  int sent = 0;
  int phases = 0;

  raised_cosine_trajectory_generator_unit i_dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .time_now,
    .out_valid, .out_stall,
    .pos_x, .pos_y, .pos_z, .vel_x, .vel_y, .vel_z, .finished
  );

  initial forever #5 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  // Receiver: random stall, changed on falling edges.
  initial forever begin
    @(negedge clk);
    out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 21);
  end

  // Result monitor: sample at the rising edge, before it updates.
  initial forever begin
    setpoint_t got;
    @(posedge clk);
    if (!rst && out_valid && !out_stall) begin
      got.px = pos_x; got.py = pos_y; got.pz = pos_z;
      got.vx = vel_x; got.vy = vel_y; got.vz = vel_z;
      got.fin = finished;
      board.check_result(got);
    end
  end

  // All three registers, one per falling edge; call only while idle.
  task automatic set_regs(bit [23:0] a, bit [23:0] f, bit [2:0] en);
    cfg_write <= 1; cfg_index <= rct_pkg::REG_AMPLITUDE; cfg_data <= a;
    @(negedge clk);
    cfg_index <= rct_pkg::REG_FREQUENCY; cfg_data <= f;
    @(negedge clk);
    cfg_index <= rct_pkg::REG_AXIS_EN; cfg_data <= {21'd0, en};
    @(negedge clk);
    cfg_write <= 0;
    board.amp = longint'(signed'(a));
    board.freq = longint'(f);
    board.axes = en;
    phases++;
  endtask

  // One time-sample request; entered and left on a falling edge.
  task automatic send_sample(bit [31:0] t);
    while (!quiet && $urandom_range(0, 99) < 21) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    time_now <= t;
    do @(posedge clk); while (in_stall);
    board.note_request(t);
    sent++;
    @(negedge clk);
  endtask

  // Hold the sender until every set-point is back, then let the pipe settle.
  task automatic drain();
    in_valid <= 0;
    while (board.owed.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  function automatic bit [23:0] pick_amp();
    case ($urandom_range(0, 3))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic bit [23:0] pick_freq();
    case ($urandom_range(0, 4))
      0: return 24'h0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(1, 24'h3FFFF));
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    bit [31:0] t;
    bit [31:0] t_pts [8] = '{32'h0, 32'h4000, 32'h8000, 32'hC000, 32'hFFFF,
                             32'h1_0000, 32'h1_0001, 32'h1_8000};
    repeat (11) @(posedge clk);
    rst <= 0;
    @(negedge clk);

    // Reset registers: zero frequency, all axes off.
    send_sample(32'h0);
    send_sample(32'hFFFF_FFFF);
    drain();

    // Zero frequency with motion enabled: phase stays 0, finished stays low.
    set_regs(24'h7FFFFF, 24'h0, 3'b111);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h1234_5678);
    drain();

    // 1 Hz, full amplitude: quarter points, saturating half turn, period edge.
    set_regs(24'h7FFFFF, 24'h010000, 3'b111);
    foreach (t_pts[i])
      send_sample(t_pts[i]);
    drain();

    // Most negative amplitude, top frequency, axes x and z; then none.
    set_regs(24'h800000, 24'hFFFFFF, 3'b101);
    send_sample(32'h1);
    send_sample(32'h100);
    send_sample(32'hFFFF_FFFF);
    drain();
    set_regs(24'h400000, 24'h020000, 3'b000);
    send_sample(32'h2000);
    send_sample(32'hAAAA_5555);
    drain();

    // Random phases; one phase runs with no idling on either side.
    for (int ph = 0; ph < 8; ph++) begin
      set_regs(pick_amp(), pick_freq(), 3'($urandom));
      quiet = (ph == 3);
      for (int n = 0; n < 80; n++) begin
        t = $urandom;
        if ($urandom_range(0, 1)) t = t >> $urandom_range(0, 31);
        send_sample(t);
      end
      drain();
      quiet = 0;
    end

    $display("Covered %0d samples over %0d register settings, %0d set-points checked.",
             sent, phases, board.seen);
    if (board.fails == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire
